>>> hw/rtl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg: shared definitions for the four-lane Hsiao(13,8) codec
// Operation and status codes, the lane result bundle and the check-bit
// function that every lane uses.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int LANES      = 4;
    localparam int BYTE_W     = 8;
    localparam int CHECK_W    = 5;
    localparam int CODE_W     = BYTE_W + CHECK_W;
    localparam int SLOT_W     = 16;
    localparam int WORD_W     = LANES * SLOT_W;

    // Operation selector carried with each input word.
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // Lane and word status, ordered so that a larger code is worse.
    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_CORR    = 2'd1;
    localparam logic [1:0] ST_UNCORR  = 2'd2;

    // Syndrome produced by a flip of each data bit, d0 first.
    localparam logic [CHECK_W-1:0] DATA_COLUMN [BYTE_W] = '{
        5'h07, 5'h0B, 5'h13, 5'h0D, 5'h15, 5'h19, 5'h0E, 5'h16
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;    // {~check, byte} for encode
        logic [BYTE_W-1:0] fixed;   // corrected byte for decode
        logic [1:0]        status;  // decode status of this lane
    } t_lane_res;

    function automatic logic [CHECK_W-1:0] check_bits(input logic [BYTE_W-1:0] b);
        logic [CHECK_W-1:0] c;
        c[0] = b[0] ^ b[1] ^ b[2] ^ b[3] ^ b[4] ^ b[5];
        c[1] = b[0] ^ b[1] ^ b[2] ^ b[6] ^ b[7];
        c[2] = b[0] ^ b[3] ^ b[4] ^ b[6] ^ b[7];
        c[3] = b[1] ^ b[3] ^ b[5] ^ b[6];
        c[4] = b[2] ^ b[4] ^ b[5] ^ b[7];
        return c;
    endfunction

endpackage

>>> hw/rtl/hsiao_secded_13_8_x4_codec.sv
// ----------------------------------------------------------------------------
// hsiao_secded_13_8_x4_codec: four-lane Hsiao(13,8) SECDED encoder/decoder
// Throughput: one word per cycle while the receiver takes every result; the
// lane XOR trees and the merge sit in front of the output and skid registers.
// Reset: synchronous, active low; it empties the output and skid stages.
// ----------------------------------------------------------------------------
module hsiao_secded_13_8_x4_codec
    import hsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,   // [63:0] operand
    input  logic              s_axis_tuser,   // [0] kind: 0 encode, 1 decode
    // Output stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [WORD_W-1:0] m_axis_tdata,   // [63:0] result_value
    output logic [1:0]        m_axis_tuser    // [1:0] check_status
);

    // Each lane sees its own byte of the low half for encoding and its own
    // 16-bit slot for decoding; the merge then selects by operation.
    t_lane_res [LANES-1:0] w_res;
    logic [WORD_W-1:0]     w_value;
    logic [1:0]            w_status;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        hsc_lane u_lane (
            .i_enc_byte (s_axis_tdata[g*BYTE_W +: BYTE_W]),
            .i_slot     (s_axis_tdata[g*SLOT_W +: SLOT_W]),
            .o_res      (w_res[g])
        );
    end

    hsc_merge u_merge (
        .i_kind   (s_axis_tuser),
        .i_res    (w_res),
        .o_value  (w_value),
        .o_status (w_status)
    );

    // Output register backed by a one-word skid register. The input side is
    // ready whenever the skid register is free, so a new word is taken even
    // while a finished word waits at the output; ready comes from a flop alone,
    // which keeps the two sides apart in timing.
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data,  n_out_data;
    logic [1:0]        r_out_user,  n_out_user;
    logic              r_skid_valid, n_skid_valid;
    logic [WORD_W-1:0] r_skid_data,  n_skid_data;
    logic [1:0]        r_skid_user,  n_skid_user;

    logic w_in_fire;
    logic w_out_free;

    assign s_axis_tready = ~r_skid_valid;
    assign w_in_fire     = s_axis_tvalid & ~r_skid_valid;
    assign w_out_free    = ~r_out_valid | m_axis_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        n_skid_user  = r_skid_user;
        if (w_out_free) begin
            if (r_skid_valid) begin
                // The parked word moves up; no input is taken this cycle.
                n_out_valid  = 1'b1;
                n_out_data   = r_skid_data;
                n_out_user   = r_skid_user;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = w_in_fire;
                n_out_data  = w_value;
                n_out_user  = w_status;
            end
        end else if (w_in_fire) begin
            // Output is stalled: park the new result.
            n_skid_valid = 1'b1;
            n_skid_data  = w_value;
            n_skid_user  = w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
        r_skid_data <= n_skid_data;
        r_skid_user <= n_skid_user;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

>>> hw/rtl/hsc_lane.sv
// ----------------------------------------------------------------------------
// hsc_lane: one Hsiao(13,8) lane
// Encodes one byte and, in parallel, checks and corrects the 13-bit code in one 16-bit slot.
// ----------------------------------------------------------------------------
module hsc_lane
    import hsc_pkg::*;
(
    input  logic [BYTE_W-1:0] i_enc_byte,
    input  logic [SLOT_W-1:0] i_slot,
    output t_lane_res         o_res
);

    logic [BYTE_W-1:0]  w_byte;
    logic [CHECK_W-1:0] w_syn;
    logic [BYTE_W-1:0]  w_flip;
    logic               w_check_err;

    assign w_byte = i_slot[BYTE_W-1:0];
    assign w_syn  = check_bits(w_byte) ^ ~i_slot[CODE_W-1:BYTE_W];

    // A syndrome of weight one points at a stored check bit.
    assign w_check_err = (w_syn != '0) && ((w_syn & (w_syn - CHECK_W'(1))) == '0);

    always_comb begin
        for (int k = 0; k < BYTE_W; k++) begin
            w_flip[k] = (w_syn == DATA_COLUMN[k]);
        end
    end

    always_comb begin
        o_res.code  = {~check_bits(i_enc_byte), i_enc_byte};
        o_res.fixed = w_byte ^ w_flip;
        if (w_syn == '0) begin
            o_res.status = ST_NONE;
        end else if (w_check_err || (w_flip != '0)) begin
            o_res.status = ST_CORR;
        end else begin
            o_res.status = ST_UNCORR;
        end
    end

endmodule

>>> hw/rtl/hsc_merge.sv
// ----------------------------------------------------------------------------
// hsc_merge: lane merge
// Packs the lane results into the output word and picks the worst lane status on decode.
// ----------------------------------------------------------------------------
module hsc_merge
    import hsc_pkg::*;
(
    input  logic                  i_kind,
    input  t_lane_res [LANES-1:0] i_res,
    output logic [WORD_W-1:0]     o_value,
    output logic [1:0]            o_status
);

    logic [WORD_W-1:0] w_enc;
    logic [WORD_W-1:0] w_dec;
    logic [1:0]        w_worst;

    always_comb begin
        w_enc   = '0;
        w_dec   = '0;
        w_worst = ST_NONE;
        for (int i = 0; i < LANES; i++) begin
            w_enc[i*SLOT_W +: SLOT_W] = {{(SLOT_W-CODE_W){1'b0}}, i_res[i].code};
            w_dec[i*BYTE_W +: BYTE_W] = i_res[i].fixed;
            if (i_res[i].status > w_worst) begin
                w_worst = i_res[i].status;
            end
        end
    end

    always_comb begin
        case (i_kind)
            KIND_ENCODE: begin
                o_value  = w_enc;
                o_status = ST_NONE;
            end
            KIND_DECODE: begin
                o_value  = w_dec;
                o_status = w_worst;
            end
            default: begin
                o_value  = w_enc;
                o_status = ST_NONE;
            end
        endcase
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the four-lane Hsiao(13,8) SECDED codec
// A queue of encode and decode words feeds a stream driver with random gaps.
// A monitor predicts every accepted word with an independent parity model,
// and it checks each result word in order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top
    import hsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // One input word and one result word; the result fields follow the port order.
    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] operand;
    } t_codec_in;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [1:0]        status;
    } t_codec_out;

    // Data bits that feed each check bit, c0 first. A data bit's syndrome
    // column is the set of check bits whose mask holds that bit.
    localparam logic [BYTE_W-1:0] PARITY_MASK [CHECK_W] = '{
        8'h3F, 8'hC7, 8'hD9, 8'h6A, 8'hB4
    };

    localparam int RANDOM_WORDS = 550;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata = '0;   // [63:0] operand
    logic              s_axis_tuser = 1'b0; // [0] kind: 0 encode, 1 decode
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [WORD_W-1:0] m_axis_tdata;        // [63:0] result_value
    logic [1:0]        m_axis_tuser;        // [1:0] check_status

    t_codec_in  pending_words[$];
    t_codec_out expected_results[$];

    // Handshake flags sampled at the rising edge and used by the drivers
    // at the following falling edge.
    logic word_taken = 1'b0;
    logic result_taken = 1'b0;
    logic hold_results = 1'b0;

    int words_offered = 0;
    int results_seen = 0;
    int total_words = 0;
    int fail_count = 0;
    int send_gap = 0;
    int recv_stall = 0;

    hsiao_secded_13_8_x4_codec DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Reset is released on a falling edge.
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #500_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Raw check bits of one data byte, before the storage inversion.
    function automatic logic [CHECK_W-1:0] lane_parity(input logic [BYTE_W-1:0] b);
        logic [CHECK_W-1:0] p;
        for (int j = 0; j < CHECK_W; j++) begin
            p[j] = ^(b & PARITY_MASK[j]);
        end
        return p;
    endfunction

    function automatic t_codec_out predict_codec(input t_codec_in w);
        t_codec_out         r;
        logic [CODE_W-1:0]  slot;
        logic [BYTE_W-1:0]  b;
        logic [BYTE_W-1:0]  flip;
        logic [CHECK_W-1:0] syn;
        logic [CHECK_W-1:0] col;
        logic [1:0]         lane_st;
        r = '0;
        for (int i = 0; i < LANES; i++) begin
            if (w.kind == KIND_ENCODE) begin
                // Only the low 32 bits of the operand take part in encoding.
                b = w.operand[BYTE_W*i +: BYTE_W];
                r.value[SLOT_W*i +: CODE_W] = {~lane_parity(b), b};
            end else begin
                // The top three bits of every slot are don't-care on decode.
                slot = w.operand[SLOT_W*i +: CODE_W];
                b = slot[BYTE_W-1:0];
                syn = lane_parity(b) ^ ~slot[CODE_W-1:BYTE_W];
                flip = '0;
                for (int k = 0; k < BYTE_W; k++) begin
                    for (int j = 0; j < CHECK_W; j++) begin
                        col[j] = PARITY_MASK[j][k];
                    end
                    if (syn == col) begin
                        flip[k] = 1'b1;
                    end
                end
                // A single-bit syndrome is a check-bit error: it counts as
                // corrected while the data byte stays untouched. Any other
                // nonzero syndrome off the data columns is uncorrectable,
                // and that lane's byte passes through as it came.
                if (syn == '0) begin
                    lane_st = ST_NONE;
                end else if ($countones(syn) == 1 || flip != '0) begin
                    lane_st = ST_CORR;
                end else begin
                    lane_st = ST_UNCORR;
                end
                r.value[BYTE_W*i +: BYTE_W] = b ^ flip;
                if (lane_st > r.status) begin
                    r.status = lane_st;
                end
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [WORD_W-1:0] codeword_of(input logic [31:0] data);
        t_codec_in  w;
        t_codec_out r;
        w.kind = KIND_ENCODE;
        w.operand = {32'b0, data};
        r = predict_codec(w);
        return r.value;
    endfunction

    // A clean codeword with per-lane damage: mostly no error or one flipped
    // bit, sometimes two, sometimes a random slot. Top slot bits are random.
    function automatic logic [WORD_W-1:0] damaged_codeword();
        logic [WORD_W-1:0] cw;
        logic [31:0]       rnd;
        int pick;
        int a;
        int b;
        cw = codeword_of($urandom);
        for (int i = 0; i < LANES; i++) begin
            pick = $urandom_range(0, 19);
            a = $urandom_range(0, CODE_W - 1);
            b = (a + $urandom_range(1, CODE_W - 1)) % CODE_W;
            if (pick >= 8 && pick < 15) begin
                cw[SLOT_W*i + a] = ~cw[SLOT_W*i + a];
            end else if (pick >= 15 && pick < 18) begin
                cw[SLOT_W*i + a] = ~cw[SLOT_W*i + a];
                cw[SLOT_W*i + b] = ~cw[SLOT_W*i + b];
            end else if (pick >= 18) begin
                rnd = $urandom;
                cw[SLOT_W*i +: CODE_W] = rnd[CODE_W-1:0];
            end
            rnd = $urandom;
            cw[SLOT_W*i + CODE_W +: SLOT_W - CODE_W] = rnd[SLOT_W-CODE_W-1:0];
        end
        return cw;
    endfunction

    task automatic add_word(input logic kind, input logic [WORD_W-1:0] operand);
        t_codec_in w;
        w.kind = kind;
        w.operand = operand;
        pending_words.push_back(w);
    endtask

    // Gap or stall before a word: long stretches without any idling
    // alternate with stretches of random waits.
    function automatic int draw_wait(input int n);
        if ((n % 128) < 40) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    // ------------------------------------------------------------------
    // Stream driver: offers words from the queue, with a drawn gap after each taken word.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : word_driver
        logic      nxt_valid;
        t_codec_in nxt;
        nxt_valid = s_axis_tvalid;
        nxt.kind = s_axis_tuser;
        nxt.operand = s_axis_tdata;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (s_axis_tvalid && word_taken) begin
                nxt_valid = 1'b0;
                send_gap = draw_wait(words_offered);
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() > 0) begin
                    nxt = pending_words.pop_front();
                    nxt_valid = 1'b1;
                    words_offered++;
                end
            end
        end
        s_axis_tvalid <= nxt_valid;
        s_axis_tuser <= nxt.kind;
        s_axis_tdata <= nxt.operand;
    end

    // ------------------------------------------------------------------
    // Receiver: stalls for a random wait after each result word, and takes
    // nothing at all while the long hold is on.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : result_receiver
        logic nxt_ready;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            if (result_taken) begin
                recv_stall = draw_wait(results_seen + 64);
            end
            if (hold_results) begin
                nxt_ready = 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
            end else begin
                nxt_ready = 1'b1;
            end
        end
        m_axis_tready <= nxt_ready;
    end

    // Once, the receiver holds off long enough for the codec to fill its
    // output and skid stages and push back on the sender.
    initial begin
        wait (results_seen >= 100);
        @(posedge i_clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_results <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts accepted input words and checks result words.
    // ------------------------------------------------------------------
    task automatic report_field(input string field, input logic [WORD_W-1:0] want,
                                input logic [WORD_W-1:0] got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch on result word %0d, %s: expected %h, got %h",
                     results_seen, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : word_monitor
        t_codec_out got;
        t_codec_out want;
        t_codec_in  seen;
        word_taken <= s_axis_tvalid && s_axis_tready;
        result_taken <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n) begin
            // The codec registers its results, so a result word never
            // belongs to an input word accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.value = m_axis_tdata;
                got.status = m_axis_tuser;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result word %0d: %h status %0d",
                                 results_seen, got.value, got.status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value) begin
                        report_field("result_value", want.value, got.value);
                    end
                    if (got.status !== want.status) begin
                        report_field("check_status", want.status, got.status);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen.kind = s_axis_tuser;
                seen.operand = s_axis_tdata;
                expected_results.push_back(predict_codec(seen));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [WORD_W-1:0] base;
        int roll;
        base = codeword_of(32'h5A3C_96E1);

        // Encode extremes, with and without garbage in the ignored upper half.
        add_word(KIND_ENCODE, 64'h0);
        add_word(KIND_ENCODE, 64'h0000_0000_FFFF_FFFF);
        add_word(KIND_ENCODE, 64'hFFFF_FFFF_1234_5678);
        add_word(KIND_ENCODE, {64{1'b1}});

        // Clean codewords, clean with all top slot bits set, and the
        // all-zero and all-one patterns, which are both uncorrectable.
        add_word(KIND_DECODE, codeword_of(32'h0));
        add_word(KIND_DECODE, codeword_of(32'hFFFF_FFFF));
        add_word(KIND_DECODE, base | 64'hE000_E000_E000_E000);
        add_word(KIND_DECODE, 64'h0);
        add_word(KIND_DECODE, {64{1'b1}});

        // Each data bit flipped once, spread over the lanes.
        for (int k = 0; k < BYTE_W; k++) begin
            add_word(KIND_DECODE, base ^ (64'h1 << (SLOT_W*(k % LANES) + k)));
        end
        // Each stored check bit flipped once.
        for (int j = 0; j < CHECK_W; j++) begin
            add_word(KIND_DECODE, base ^ (64'h1 << (SLOT_W*(j % LANES) + BYTE_W + j)));
        end
        // Two data bits in one lane, then a corrected lane in the same word as
        // a lane with a data and a check bit both flipped.
        add_word(KIND_DECODE, base ^ (64'h3 << (SLOT_W*2 + 3)));
        add_word(KIND_DECODE, base ^ 64'h0201_0000_0000_0002);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 9);
            if (roll < 4) begin
                add_word(KIND_ENCODE, {$urandom, $urandom});
            end else if (roll < 9) begin
                add_word(KIND_DECODE, damaged_codeword());
            end else begin
                add_word(KIND_DECODE, {$urandom, $urandom});
            end
        end
        total_words = pending_words.size();

        wait (results_seen >= total_words);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            fail_count++;
            $display("%0d result words never arrived", expected_results.size());
        end
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> hsiao_secded_13_8_x4_codec.f
hw/rtl/hsc_pkg.sv
hw/rtl/hsc_lane.sv
hw/rtl/hsc_merge.sv
hw/rtl/hsiao_secded_13_8_x4_codec.sv
test/tb_top.sv
